>>> sv/irpdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared widths, register indexes, reset values and types of the IR
// pulse-distance transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

    localparam int PAYLOAD_W = 24;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int PAYLOAD_BYTES_DEF = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd6;

    // Register values after reset.
    localparam logic [TICK_W-1:0] LEAD_MARK_RST  = 16'd70;
    localparam logic [TICK_W-1:0] LEAD_SPACE_RST = 16'd70;
    localparam logic [TICK_W-1:0] BIT_MARK_RST   = 16'd8;
    localparam logic [TICK_W-1:0] ONE_SPACE_RST  = 16'd26;
    localparam logic [TICK_W-1:0] ZERO_SPACE_RST = 16'd8;
    localparam logic [TICK_W-1:0] END_MARK_RST   = 16'd8;
    localparam logic [TICK_W-1:0] GAP_RST        = 16'd78;

    typedef struct packed {
        logic [TICK_W-1:0] lead_mark;
        logic [TICK_W-1:0] lead_space;
        logic [TICK_W-1:0] bit_mark;
        logic [TICK_W-1:0] one_space;
        logic [TICK_W-1:0] zero_space;
        logic [TICK_W-1:0] end_mark;
        logic [TICK_W-1:0] gap;
    } cfg_t;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
    } result_t;

endpackage

>>> sv/irpdt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpdt_cfg
// Configuration register file holding the seven phase durations.
// ----------------------------------------------------------------------------
module irpdt_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [irpdt_pkg::TICK_W-1:0]    wr_data,
    output irpdt_pkg::cfg_t                 cfg
);

    irpdt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_mark  <= irpdt_pkg::LEAD_MARK_RST;
            cfg_reg.lead_space <= irpdt_pkg::LEAD_SPACE_RST;
            cfg_reg.bit_mark   <= irpdt_pkg::BIT_MARK_RST;
            cfg_reg.one_space  <= irpdt_pkg::ONE_SPACE_RST;
            cfg_reg.zero_space <= irpdt_pkg::ZERO_SPACE_RST;
            cfg_reg.end_mark   <= irpdt_pkg::END_MARK_RST;
            cfg_reg.gap        <= irpdt_pkg::GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                irpdt_pkg::CFG_LEAD_MARK:  cfg_reg.lead_mark  <= wr_data;
                irpdt_pkg::CFG_LEAD_SPACE: cfg_reg.lead_space <= wr_data;
                irpdt_pkg::CFG_BIT_MARK:   cfg_reg.bit_mark   <= wr_data;
                irpdt_pkg::CFG_ONE_SPACE:  cfg_reg.one_space  <= wr_data;
                irpdt_pkg::CFG_ZERO_SPACE: cfg_reg.zero_space <= wr_data;
                irpdt_pkg::CFG_END_MARK:   cfg_reg.end_mark   <= wr_data;
                irpdt_pkg::CFG_GAP:        cfg_reg.gap        <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/irpdt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpdt_core
// Input register and frame sequencer: phase timer, bit counter, payload
// store and carrier gate. Produces one result per processed item.
// ----------------------------------------------------------------------------
module irpdt_core #(
    parameter int PAYLOAD_BYTES = irpdt_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [irpdt_pkg::PAYLOAD_W-1:0] payload,
    input  irpdt_pkg::cfg_t                 cfg,
    input  logic                            room,
    output logic                            push,
    output irpdt_pkg::result_t              push_data
);

    localparam int TOTAL_BITS = 16 * PAYLOAD_BYTES;
    localparam int BIT_W      = $clog2(TOTAL_BITS);
    localparam int TW         = irpdt_pkg::TICK_W;
    localparam int PW         = irpdt_pkg::PAYLOAD_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_END_MARK,
        PH_GAP
    } phase_t;

    // Input register.
    logic          in_valid_reg;
    logic          action_reg;
    logic [PW-1:0] payload_reg;

    // Sequencer state.
    phase_t           phase_reg, phase_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic [TW-1:0]    len_reg, len_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             second_reg, second_next;
    logic [PW-1:0]    store_reg, store_next;
    logic             carrier_reg, carrier_next;

    logic             go;
    logic             take;
    logic [TW:0]      tick_inc;
    logic [BIT_W:0]   bit_inc;
    logic [BIT_W-4:0] byte_pos;
    logic [1:0]       byte_sel;
    logic [31:0]      store_ext;
    logic [7:0]       cur_byte;
    logic             cur_bit;

    assign go       = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign take     = in_valid && !in_stall;

    // Byte slot within the frame: even slots are true bytes, odd slots their
    // complements. Bytes are taken from the top of the store down.
    assign byte_pos  = bit_reg[BIT_W-1:3];
    assign byte_sel  = 2'(PAYLOAD_BYTES - 1 - int'(byte_pos >> 1));
    assign store_ext = {8'h00, store_reg};
    assign cur_byte  = byte_pos[0] ? ~store_ext[8*byte_sel +: 8] : store_ext[8*byte_sel +: 8];
    assign cur_bit   = cur_byte[3'd7 - bit_reg[2:0]];

    assign tick_inc = {1'b0, tick_reg} + 1'b1;
    assign bit_inc  = {1'b0, bit_reg} + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        len_next     = len_reg;
        bit_next     = bit_reg;
        second_next  = second_reg;
        store_next   = store_reg;
        carrier_next = carrier_reg;

        if (go)
        begin
            if (action_reg)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    store_next   = payload_reg;
                    tick_next    = '0;
                    bit_next     = '0;
                    second_next  = 1'b0;
                    phase_next   = PH_LEAD_MARK;
                    len_next     = cfg.lead_mark;
                    carrier_next = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (tick_inc < {1'b0, len_reg})
                begin
                    tick_next = tick_inc[TW-1:0];
                end
                else
                begin
                    tick_next = '0;
                    unique case (phase_reg)
                        PH_LEAD_MARK:
                        begin
                            phase_next   = PH_LEAD_SPACE;
                            len_next     = cfg.lead_space;
                            carrier_next = 1'b0;
                        end
                        PH_LEAD_SPACE:
                        begin
                            phase_next   = PH_BIT_MARK;
                            len_next     = cfg.bit_mark;
                            carrier_next = 1'b1;
                        end
                        PH_BIT_MARK:
                        begin
                            phase_next   = PH_BIT_SPACE;
                            len_next     = cur_bit ? cfg.one_space : cfg.zero_space;
                            carrier_next = 1'b0;
                        end
                        PH_BIT_SPACE:
                        begin
                            bit_next     = bit_inc[BIT_W-1:0];
                            carrier_next = 1'b1;
                            if (bit_inc >= (BIT_W+1)'(TOTAL_BITS))
                            begin
                                phase_next = PH_END_MARK;
                                len_next   = cfg.end_mark;
                            end
                            else
                            begin
                                phase_next = PH_BIT_MARK;
                                len_next   = cfg.bit_mark;
                            end
                        end
                        PH_END_MARK:
                        begin
                            phase_next   = PH_GAP;
                            len_next     = cfg.gap;
                            carrier_next = 1'b0;
                        end
                        PH_GAP:
                        begin
                            if (!second_reg)
                            begin
                                second_next  = 1'b1;
                                bit_next     = '0;
                                phase_next   = PH_LEAD_MARK;
                                len_next     = cfg.lead_mark;
                                carrier_next = 1'b1;
                            end
                            else
                            begin
                                phase_next   = PH_IDLE;
                                carrier_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next   = PH_IDLE;
                            carrier_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    assign push                 = go;
    assign push_data.carrier_on = carrier_next;
    assign push_data.busy_res   = (phase_next != PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            len_reg      <= '0;
            bit_reg      <= '0;
            second_reg   <= 1'b0;
            carrier_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            len_reg     <= len_next;
            bit_reg     <= bit_next;
            second_reg  <= second_next;
            carrier_reg <= carrier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg  <= action;
            payload_reg <= payload;
        end
        store_reg <= store_next;
    end

endmodule

>>> sv/irpdt_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpdt_outq
// Two-entry result buffer: a head register that drives the output port and
// a skid register that catches a result while the head is stalled.
// ----------------------------------------------------------------------------
module irpdt_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  irpdt_pkg::result_t push_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output irpdt_pkg::result_t out_data
);

    logic [1:0]         count_reg;
    irpdt_pkg::result_t head_reg;
    irpdt_pkg::result_t skid_reg;
    logic               pop;

    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // With two entries held no push can occur, so the skid moves up.
            head_reg <= (count_reg == 2'd2) ? skid_reg : push_data;
        end
        else if (push && count_reg == 2'd0)
        begin
            head_reg <= push_data;
        end
        if (push && !pop && count_reg == 2'd1)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

>>> sv/ir_pulse_distance_transmitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit
// Infrared pulse-distance frame transmitter with a gated carrier output.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is either a time tick or a start
// command carrying the payload bytes. The block takes one item per clock
// cycle while in_stall is low; an item passes through the input register
// and the frame sequencer into the result buffer, whose head register
// drives the output. The result gives the carrier gate and the busy flag
// after the item. A two-entry result buffer lets input keep flowing while
// the output stalls, until both entries are held. Phase durations are
// written through the configuration channel, which is always ready; a
// write takes effect for phases that begin after it.
module ir_pulse_distance_transmitter_unit #(
    parameter int PAYLOAD_BYTES = irpdt_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [irpdt_pkg::PAYLOAD_W-1:0] payload,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            carrier_on,
    output logic                            busy_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irpdt_pkg::TICK_W-1:0]    cfg_data
);

    irpdt_pkg::cfg_t    cfg;
    irpdt_pkg::result_t push_data;
    irpdt_pkg::result_t out_data;
    logic               push;
    logic               room;

    assign cfg_ready = 1'b1;

    irpdt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    irpdt_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .payload   (payload),
        .cfg       (cfg),
        .room      (room),
        .push      (push),
        .push_data (push_data)
    );

    irpdt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign carrier_on = out_data.carrier_on;
    assign busy_res   = out_data.busy_res;

endmodule

>>> dv/ir_pulse_distance_transmitter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit_tb
// Self-checking testbench for the IR pulse-distance transmitter. A cycle
// accurate software copy of the frame sequencer predicts the carrier gate
// and busy flag for every accepted item, and each result transfer is
// compared against the oldest prediction. Directed tests cover the reset
// timing, idle ticks, payload extremes, zero-length phases, a long lead
// mark and mid-frame register writes; random runs follow.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_unit_tb;

    localparam int          PAYLOAD_W     = irpdt_pkg::PAYLOAD_W;
    localparam int          TICK_W        = irpdt_pkg::TICK_W;
    localparam int          CFG_IDX_W     = irpdt_pkg::CFG_IDX_W;
    localparam int          BYTES         = irpdt_pkg::PAYLOAD_BYTES_DEF;
    localparam int          TOTAL_BITS    = 8 * 2 * BYTES;
    localparam int          CYCLE_LIMIT   = 500_000;
    localparam int          RANDOM_RUNS   = 2;
    localparam int          RUN_ITEMS     = 125;
    localparam int          DEFAULT_TICKS = 150;
    localparam logic [TICK_W-1:0] LONG_SPAN = 16'd40;
    localparam logic        ACT_TICK      = 1'b0;
    localparam logic        ACT_START     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD_MARK,
        ST_LEAD_SPACE,
        ST_BIT_MARK,
        ST_BIT_SPACE,
        ST_END_MARK,
        ST_GAP
    } tx_phase_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 action     = ACT_TICK;
    logic [PAYLOAD_W-1:0] payload    = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 carrier_on;
    logic                 busy_res;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = irpdt_pkg::CFG_LEAD_MARK;
    logic [TICK_W-1:0]    cfg_data   = '0;

    // Predictor state.
    irpdt_pkg::cfg_t      timing;
    tx_phase_t            tx_phase;
    int unsigned          phase_ticks;
    logic [TICK_W-1:0]    phase_span;
    int unsigned          bit_pos;
    logic                 repeat_frame;
    logic [PAYLOAD_W-1:0] held_payload;
    logic                 carrier_gate;

    irpdt_pkg::result_t   predicted_gate_q[$];
    irpdt_pkg::result_t   oldest;
    int                   errors  = 0;
    int                   cycles  = 0;
    bit                   steady  = 1'b0;

    ir_pulse_distance_transmitter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .payload    (payload),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .carrier_on (carrier_on),
        .busy_res   (busy_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame sequencer predictor
    // ------------------------------------------------------------------
    function automatic void clear_transmitter();
        timing.lead_mark  = irpdt_pkg::LEAD_MARK_RST;
        timing.lead_space = irpdt_pkg::LEAD_SPACE_RST;
        timing.bit_mark   = irpdt_pkg::BIT_MARK_RST;
        timing.one_space  = irpdt_pkg::ONE_SPACE_RST;
        timing.zero_space = irpdt_pkg::ZERO_SPACE_RST;
        timing.end_mark   = irpdt_pkg::END_MARK_RST;
        timing.gap        = irpdt_pkg::GAP_RST;
        tx_phase     = ST_IDLE;
        phase_ticks  = 0;
        phase_span   = '0;
        bit_pos      = 0;
        repeat_frame = 1'b0;
        held_payload = '0;
        carrier_gate = 1'b0;
    endfunction

    function automatic void enter_phase(tx_phase_t next, logic [TICK_W-1:0] span, logic on);
        tx_phase     = next;
        phase_span   = span;
        carrier_gate = on;
    endfunction

    // Odd byte slots carry the complement of the byte before them.
    function automatic logic data_bit();
        int unsigned slot;
        int unsigned shift;
        logic [7:0]  octet;
        slot  = (bit_pos >> 3) % (2 * BYTES);
        shift = 8 * (BYTES - 1 - (slot >> 1));
        octet = 8'(held_payload >> shift);
        if (slot[0])
            octet = ~octet;
        return octet[3'd7 - bit_pos[2:0]];
    endfunction

    function automatic void advance_tick();
        if (tx_phase == ST_IDLE)
            return;
        phase_ticks++;
        // A zero span ends on the first tick, the same as a span of one.
        if (phase_ticks < phase_span)
            return;
        phase_ticks = 0;
        case (tx_phase)
            ST_LEAD_MARK:  enter_phase(ST_LEAD_SPACE, timing.lead_space, 1'b0);
            ST_LEAD_SPACE: enter_phase(ST_BIT_MARK, timing.bit_mark, 1'b1);
            ST_BIT_MARK:
                enter_phase(ST_BIT_SPACE,
                            data_bit() ? timing.one_space : timing.zero_space, 1'b0);
            ST_BIT_SPACE:
            begin
                bit_pos++;
                if (bit_pos >= TOTAL_BITS)
                    enter_phase(ST_END_MARK, timing.end_mark, 1'b1);
                else
                    enter_phase(ST_BIT_MARK, timing.bit_mark, 1'b1);
            end
            ST_END_MARK:   enter_phase(ST_GAP, timing.gap, 1'b0);
            ST_GAP:
            begin
                if (!repeat_frame)
                begin
                    repeat_frame = 1'b1;
                    bit_pos      = 0;
                    enter_phase(ST_LEAD_MARK, timing.lead_mark, 1'b1);
                end
                else
                begin
                    tx_phase     = ST_IDLE;
                    carrier_gate = 1'b0;
                end
            end
            default:
            begin
                tx_phase     = ST_IDLE;
                carrier_gate = 1'b0;
            end
        endcase
    endfunction

    function automatic irpdt_pkg::result_t step_transmitter(logic act,
                                                            logic [PAYLOAD_W-1:0] data);
        irpdt_pkg::result_t res;
        if (act == ACT_START)
        begin
            // A start during a transmission is dropped.
            if (tx_phase == ST_IDLE)
            begin
                held_payload = data;
                phase_ticks  = 0;
                bit_pos      = 0;
                repeat_frame = 1'b0;
                enter_phase(ST_LEAD_MARK, timing.lead_mark, 1'b1);
            end
        end
        else
            advance_tick();
        res.carrier_on = carrier_gate;
        res.busy_res   = (tx_phase != ST_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [PAYLOAD_W-1:0] data);
        while (!steady && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        payload  <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_gate_q.push_back(step_transmitter(act, data));
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            irpdt_pkg::CFG_LEAD_MARK:  timing.lead_mark  = data;
            irpdt_pkg::CFG_LEAD_SPACE: timing.lead_space = data;
            irpdt_pkg::CFG_BIT_MARK:   timing.bit_mark   = data;
            irpdt_pkg::CFG_ONE_SPACE:  timing.one_space  = data;
            irpdt_pkg::CFG_ZERO_SPACE: timing.zero_space = data;
            irpdt_pkg::CFG_END_MARK:   timing.end_mark   = data;
            irpdt_pkg::CFG_GAP:        timing.gap        = data;
            default: ;
        endcase
    endtask

    task automatic program_timing(input irpdt_pkg::cfg_t t);
        put_reg(irpdt_pkg::CFG_LEAD_MARK,  t.lead_mark);
        put_reg(irpdt_pkg::CFG_LEAD_SPACE, t.lead_space);
        put_reg(irpdt_pkg::CFG_BIT_MARK,   t.bit_mark);
        put_reg(irpdt_pkg::CFG_ONE_SPACE,  t.one_space);
        put_reg(irpdt_pkg::CFG_ZERO_SPACE, t.zero_space);
        put_reg(irpdt_pkg::CFG_END_MARK,   t.end_mark);
        put_reg(irpdt_pkg::CFG_GAP,        t.gap);
        cfg_valid <= 1'b0;
    endtask

    // Stops the sender and waits for every predicted result to come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_gate_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_until_idle();
        while (tx_phase != ST_IDLE)
            send_item(ACT_TICK, PAYLOAD_W'($urandom()));
    endtask

    function automatic irpdt_pkg::cfg_t uniform_timing(logic [TICK_W-1:0] span);
        irpdt_pkg::cfg_t t;
        t = {7{span}};
        return t;
    endfunction

    // Mostly short spans so that many frames complete; zero now and then.
    function automatic logic [TICK_W-1:0] draw_span();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 75)
            return TICK_W'($urandom_range(3, 1));
        else
            return TICK_W'($urandom_range(12, 4));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Runs through both default lead phases into the first data bit, then
    // finishes the frame with short spans.
    task automatic test_default_timing();
        send_item(ACT_START, 24'hC3_5A_0F);
        repeat (5)
            send_item(ACT_TICK, PAYLOAD_W'($urandom()));
        send_item(ACT_START, 24'h12_34_56);
        repeat (DEFAULT_TICKS)
            send_item(ACT_TICK, PAYLOAD_W'($urandom()));
        drain_results();
        program_timing(uniform_timing(16'd1));
        run_until_idle();
    endtask

    task automatic test_idle_ticks();
        send_item(ACT_TICK, 24'h000000);
        send_item(ACT_TICK, 24'hFFFFFF);
        send_item(ACT_TICK, PAYLOAD_W'($urandom()));
    endtask

    task automatic test_payload_extremes();
        drain_results();
        program_timing(uniform_timing(16'd1));
        send_item(ACT_START, 24'h000000);
        run_until_idle();
        send_item(ACT_START, 24'hFFFFFF);
        send_item(ACT_TICK, 24'h000000);
        send_item(ACT_START, 24'h000000);
        run_until_idle();
    endtask

    task automatic test_zero_spans();
        drain_results();
        program_timing(uniform_timing(16'd0));
        send_item(ACT_START, 24'h96_E1_3D);
        run_until_idle();
    endtask

    // The lead mark latches a long span; a write during that mark must only
    // take effect for phases that begin later.
    task automatic test_longest_phase();
        irpdt_pkg::cfg_t t;
        t = uniform_timing(16'd1);
        t.lead_mark = LONG_SPAN;
        steady = 1'b1;
        drain_results();
        program_timing(t);
        send_item(ACT_START, PAYLOAD_W'($urandom()));
        repeat (10)
            send_item(ACT_TICK, PAYLOAD_W'($urandom()));
        drain_results();
        t.lead_mark  = 16'd2;
        t.lead_space = 16'd3;
        program_timing(t);
        while (tx_phase == ST_LEAD_MARK)
            send_item(ACT_TICK, PAYLOAD_W'($urandom()));
        run_until_idle();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        irpdt_pkg::cfg_t t;
        int   useful;
        logic busy;
        logic act;
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            drain_results();
            if (run == 0)
                t = uniform_timing(16'd1);
            else
            begin
                t.lead_mark  = draw_span();
                t.lead_space = draw_span();
                t.bit_mark   = draw_span();
                t.one_space  = draw_span();
                t.zero_space = draw_span();
                t.end_mark   = draw_span();
                t.gap        = draw_span();
            end
            program_timing(t);
            steady = (run == 1);
            useful = 0;
            while (useful < RUN_ITEMS)
            begin
                busy = (tx_phase != ST_IDLE);
                if (busy)
                    act = ($urandom_range(99) < 2) ? ACT_START : ACT_TICK;
                else
                    act = ($urandom_range(99) < 30) ? ACT_START : ACT_TICK;
                // Idle ticks and starts while busy are ignored by the block.
                if ((act == ACT_START) != busy)
                    useful++;
                send_item(act, PAYLOAD_W'($urandom()));
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_gate_q.size() == 0)
            begin
                $error("result transfer with nothing predicted: carrier_on=%0b busy_res=%0b",
                       carrier_on, busy_res);
                errors++;
            end
            else
            begin
                oldest = predicted_gate_q.pop_front();
                if (carrier_on !== oldest.carrier_on)
                begin
                    $error("carrier_on: expected %0b, got %0b", oldest.carrier_on, carrier_on);
                    errors++;
                end
                if (busy_res !== oldest.busy_res)
                begin
                    $error("busy_res: expected %0b, got %0b", oldest.busy_res, busy_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 8);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clear_transmitter();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_idle_ticks();
        test_payload_extremes();
        test_zero_spans();
        test_longest_phase();
        test_random_traffic();

        drain_results();
        repeat (10)
            @(posedge clk);
        if (predicted_gate_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_gate_q.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/irpdt_pkg.sv
sv/irpdt_cfg.sv
sv/irpdt_core.sv
sv/irpdt_outq.sv
sv/ir_pulse_distance_transmitter_unit.sv
dv/ir_pulse_distance_transmitter_unit_tb.sv
